// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros : shared assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PIP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PIP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// types, constants and edge setup shared by the point-in-polygon test unit
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int DIFF_W       = COORD_WIDTH + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int VCNT_W       = 2;
	localparam logic [VCNT_W-1:0] MIN_VERTICES = VCNT_W'(3);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t vertex_x;
		coord_t vertex_y;
		logic   last_vertex;
	} pip_in_t;

	typedef struct packed {
		logic inside_res;
		logic valid_polygon;
	} pip_out_t;

	// one edge test: crossing when en and (pos ? a*d < c*e : c*e < a*d)
	typedef struct packed {
		logic  en;
		logic  pos;
		diff_t a;
		diff_t d;
		diff_t c;
		diff_t e;
	} pip_edge_t;

	typedef struct packed {
		pip_edge_t edge_prev;
		pip_edge_t edge_close;
		logic      last;
		logic      valid_poly;
	} pip_cmd_t;

	// edge from vertex i to vertex j against the ray from the query point
	function automatic pip_edge_t make_edge(input coord_t qx, input coord_t qy,
		input coord_t xi, input coord_t yi, input coord_t xj, input coord_t yj);
		pip_edge_t r;
		r.en  = (yi > qy) != (yj > qy);
		r.d   = DIFF_W'(yj) - DIFF_W'(yi);
		r.pos = (yj > yi);
		r.a   = DIFF_W'(qx) - DIFF_W'(xi);
		r.c   = DIFF_W'(xj) - DIFF_W'(xi);
		r.e   = DIFF_W'(qy) - DIFF_W'(yi);
		return r;
	endfunction

endpackage

// ===== rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// accepts vertices, tracks polygon state and issues edge-test commands
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pip_pkg::pip_in_t  req,
	input  logic              queue_full,
	output logic              push,
	output pip_pkg::pip_cmd_t cmd
);

	logic [pip_pkg::VCNT_W-1:0] count_q;
	logic [pip_pkg::VCNT_W-1:0] count_nxt;
	pip_pkg::coord_t            query_x_q, query_y_q;
	pip_pkg::coord_t            first_x_q, first_y_q;
	pip_pkg::coord_t            prev_x_q, prev_y_q;
	pip_pkg::coord_t            qx, qy, fx, fy;
	logic                       is_first;

	assign req_ready = !queue_full;
	assign push      = req_valid && req_ready;
	assign is_first  = (count_q == '0);

	always_comb begin
		qx = is_first ? req.point_x : query_x_q;
		qy = is_first ? req.point_y : query_y_q;
		fx = is_first ? req.vertex_x : first_x_q;
		fy = is_first ? req.vertex_y : first_y_q;
		if (is_first) begin
			count_nxt = pip_pkg::VCNT_W'(1);
		end else if (count_q == pip_pkg::MIN_VERTICES) begin
			count_nxt = count_q;
		end else begin
			count_nxt = count_q + pip_pkg::VCNT_W'(1);
		end
	end

	always_comb begin
		cmd.edge_prev  = pip_pkg::make_edge(qx, qy, req.vertex_x, req.vertex_y,
			prev_x_q, prev_y_q);
		cmd.edge_close = pip_pkg::make_edge(qx, qy, fx, fy,
			req.vertex_x, req.vertex_y);
		cmd.edge_prev.en  = cmd.edge_prev.en && !is_first;
		cmd.edge_close.en = cmd.edge_close.en && req.last_vertex;
		cmd.last          = req.last_vertex;
		cmd.valid_poly    = req.last_vertex && (count_nxt == pip_pkg::MIN_VERTICES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= req.last_vertex ? '0 : count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			query_x_q <= qx;
			query_y_q <= qy;
			first_x_q <= fx;
			first_y_q <= fy;
			prev_x_q  <= req.vertex_x;
			prev_y_q  <= req.vertex_y;
		end
	end

	`PIP_ASSERT(a_count_saturates, (push && !req.last_vertex && count_q == pip_pkg::MIN_VERTICES) |=> (count_q == pip_pkg::MIN_VERTICES), "vertex count left saturation")

endmodule

// ===== rtl/pip_queue.sv =====
// ----------------------------------------------------------------------------
// pip_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pip_pkg::pip_cmd_t push_cmd,
	input  logic              pop,
	output pip_pkg::pip_cmd_t pop_cmd,
	output logic              full,
	output logic              empty
);

	pip_pkg::pip_cmd_t          mem_q [pip_pkg::QUEUE_DEPTH];
	logic [pip_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [pip_pkg::QCNT_W-1:0] count_q;

	assign full    = (count_q == pip_pkg::QCNT_W'(pip_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pip_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pip_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + pip_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - pip_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	`PIP_ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
	`PIP_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule

// ===== rtl/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back
// cross-multiplied edge tests, parity accumulation and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_empty,
	input  pip_pkg::pip_cmd_t cmd,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output pip_pkg::pip_out_t res
);

	logic              advance;
	logic              valid_s1;
	logic              last_s1, valid_poly_s1;
	logic              en_p_s1, pos_p_s1, en_c_s1, pos_c_s1;
	pip_pkg::prod_t    ad_p_s1, ce_p_s1, ad_c_s1, ce_c_s1;
	logic              cross_p, cross_c, parity_nxt;
	logic              parity_q;
	logic              res_valid_q;
	pip_pkg::pip_out_t res_q;

	assign advance   = !res_valid_q || res_ready;
	assign pop       = advance && !queue_empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// products of both edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ad_p_s1       <= cmd.edge_prev.a * cmd.edge_prev.d;
			ce_p_s1       <= cmd.edge_prev.c * cmd.edge_prev.e;
			ad_c_s1       <= cmd.edge_close.a * cmd.edge_close.d;
			ce_c_s1       <= cmd.edge_close.c * cmd.edge_close.e;
			en_p_s1       <= cmd.edge_prev.en;
			pos_p_s1      <= cmd.edge_prev.pos;
			en_c_s1       <= cmd.edge_close.en;
			pos_c_s1      <= cmd.edge_close.pos;
			last_s1       <= cmd.last;
			valid_poly_s1 <= cmd.valid_poly;
		end
	end

	// compare and parity
	always_comb begin
		cross_p    = en_p_s1 && (pos_p_s1 ? (ad_p_s1 < ce_p_s1) : (ce_p_s1 < ad_p_s1));
		cross_c    = en_c_s1 && (pos_c_s1 ? (ad_c_s1 < ce_c_s1) : (ce_c_s1 < ad_c_s1));
		parity_nxt = parity_q ^ cross_p ^ cross_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && last_s1;
			if (valid_s1) begin
				parity_q <= last_s1 ? 1'b0 : parity_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			res_q.inside_res    <= parity_nxt && valid_poly_s1;
			res_q.valid_polygon <= valid_poly_s1;
		end
	end

	`PIP_ASSERT(a_parity_cleared, (advance && valid_s1 && last_s1) |=> !parity_q, "parity not cleared after result")
	`PIP_ASSERT_NEVER(a_invalid_not_inside, res_valid_q && !res_q.valid_polygon && res_q.inside_res, "inside reported for invalid polygon")

endmodule

// ===== rtl/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// crossing-number point-in-polygon test, one polygon vertex per request.
// requests arrive on req_valid / req_ready; the first vertex of a polygon
// also latches the query point. a request with last_vertex set closes the
// polygon and yields one result on res_valid / res_ready; other requests
// yield none.
// throughput: one request per cycle while req_ready is high. a result is
// registered after the closing request is accepted, through the command
// queue, the product register and the result register.
// while the receiver stalls, the result holds and the back end stops; the
// four-entry command queue keeps taking requests until it fills, then
// req_ready drops.
// reset clears polygon state, the queue and the result valid flag; the first
// request after reset starts a new polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pip_pkg::pip_in_t  req,
	output logic              res_valid,
	input  logic              res_ready,
	output pip_pkg::pip_out_t res
);

	pip_pkg::pip_cmd_t push_cmd, pop_cmd;
	logic              push, pop, queue_full, queue_empty;

	pip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	pip_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	pip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.cmd         (pop_cmd),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule

// ===== bench/point_in_polygon_test_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit_tb
// streams polygons one vertex per request into the crossing-number test unit
// and checks every inside / valid result against a cycle-free software
// predictor of the parity walk. directed polygons cover short, degenerate,
// extreme-coordinate and long cases; random polygons follow with sender and
// receiver idling in three mixes.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_tb;
	import pip_pkg::*;

	class parity_scoreboard;
		coord_t            query_x, query_y, first_x, first_y, prev_x, prev_y;
		bit [VCNT_W-1:0]   vertex_count;
		bit                parity;
		pip_out_t          expected_q[$];
		int                errors, requests, results, inside_hits, short_polys;

		function int pending();
			return expected_q.size();
		endfunction

		function bit ray_crossed(longint xi, longint yi, longint xj, longint yj);
			longint qx, qy, dy;
			qx = query_x;
			qy = query_y;
			if ((yi > qy) == (yj > qy))
				return 1'b0;
			dy = yj - yi;
			if (dy > 0)
				return (qx - xi) * dy < (xj - xi) * (qy - yi);
			return (xj - xi) * (qy - yi) < (qx - xi) * dy;
		endfunction

		function void note_request(pip_in_t r);
			pip_out_t exp_res;
			bit       poly_ok;
			requests++;
			if (vertex_count == 0) begin
				query_x      = r.point_x;
				query_y      = r.point_y;
				first_x      = r.vertex_x;
				first_y      = r.vertex_y;
				vertex_count = 1;
			end else begin
				if (ray_crossed(r.vertex_x, r.vertex_y, prev_x, prev_y))
					parity ^= 1'b1;
				if (vertex_count < MIN_VERTICES)
					vertex_count++;
			end
			prev_x = r.vertex_x;
			prev_y = r.vertex_y;
			if (!r.last_vertex)
				return;
			if (ray_crossed(first_x, first_y, r.vertex_x, r.vertex_y))
				parity ^= 1'b1;
			poly_ok               = (vertex_count >= MIN_VERTICES);
			exp_res.inside_res    = parity & poly_ok;
			exp_res.valid_polygon = poly_ok;
			expected_q = {expected_q, exp_res};
			vertex_count = '0;
			parity       = 1'b0;
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(pip_out_t got);
			pip_out_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
				return;
			end
			want = expected_q.pop_front();
			results++;
			if (want.inside_res)
				inside_hits++;
			if (!want.valid_polygon)
				short_polys++;
			if (got.inside_res !== want.inside_res)
				report_mismatch("inside_res", got.inside_res, want.inside_res);
			if (got.valid_polygon !== want.valid_polygon)
				report_mismatch("valid_polygon", got.valid_polygon, want.valid_polygon);
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	pip_in_t  req;
	logic     res_valid;
	logic     res_ready;
	pip_out_t res;

	parity_scoreboard sb = new();
	int send_idle_pct;
	int recv_stall_pct;

	point_in_polygon_test_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n)
			res_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res);
	end

	task automatic send_request(pip_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = item;
		do @(posedge clk); while (!req_ready);
		sb.note_request(item);
		@(negedge clk);
	endtask

	task automatic send_vertex(int px, int py, int vx, int vy, bit last);
		pip_in_t item;
		item.point_x     = coord_t'(px);
		item.point_y     = coord_t'(py);
		item.vertex_x    = coord_t'(vx);
		item.vertex_y    = coord_t'(vy);
		item.last_vertex = last;
		send_request(item);
	endtask

	task automatic wait_for_results();
		req_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic coord_t near_coord(coord_t c, int span);
		longint v;
		v = longint'(c) + longint'($urandom_range(2 * span)) - span;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	function automatic coord_t corner_coord(coord_t q);
		case ($urandom_range(4))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(0);
			3: return coord_t'(-1);
			default: return q;
		endcase
	endfunction

	task automatic send_random_polygon();
		int      pick, nverts, style, span;
		coord_t  qx, qy;
		pip_in_t item;
		pick = $urandom_range(99);
		if (pick < 8)
			nverts = $urandom_range(2, 1);
		else if (pick < 14)
			nverts = $urandom_range(24, 9);
		else
			nverts = $urandom_range(8, 3);
		style = $urandom_range(3);
		span  = $urandom_range(3000, 1);
		qx    = coord_t'($urandom);
		qy    = coord_t'($urandom);
		if (style == 2) begin
			qx = coord_t'(int'($urandom_range(16)) - 8);
			qy = coord_t'(int'($urandom_range(16)) - 8);
		end
		for (int i = 0; i < nverts; i++) begin
			item.point_x = (i == 0) ? qx : coord_t'($urandom);
			item.point_y = (i == 0) ? qy : coord_t'($urandom);
			case (style)
				0: begin
					item.vertex_x = near_coord(qx, span);
					item.vertex_y = near_coord(qy, span);
				end
				1: begin
					item.vertex_x = coord_t'($urandom);
					item.vertex_y = coord_t'($urandom);
				end
				2: begin
					item.vertex_x = coord_t'(int'($urandom_range(16)) - 8);
					item.vertex_y = coord_t'(int'($urandom_range(16)) - 8);
				end
				default: begin
					item.vertex_x = corner_coord(qx);
					item.vertex_y = corner_coord(qy);
				end
			endcase
			item.last_vertex = (i == nverts - 1);
			send_request(item);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		res_ready      = 1'b0;
		send_idle_pct  = 18;
		recv_stall_pct = 66;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single vertex, two vertices
		send_vertex(0, 0, 5, 5, 1'b1);
		send_vertex(0, 0, -10, -10, 1'b0);
		send_vertex(0, 0, 10, 10, 1'b1);
		// full-range triangle, query point on later requests ignored
		send_vertex(0, 0, -32768, -32768, 1'b0);
		send_vertex(32767, -32768, 32767, -32768, 1'b0);
		send_vertex(-32768, 32767, 0, 32767, 1'b1);
		// same triangle, query at the top-right corner of the range
		send_vertex(32767, 32767, -32768, -32768, 1'b0);
		send_vertex(0, 0, 32767, -32768, 1'b0);
		send_vertex(0, 0, 0, 32767, 1'b1);
		// horizontal edge on the query line
		send_vertex(0, 0, -5, 0, 1'b0);
		send_vertex(0, 0, 5, 0, 1'b0);
		send_vertex(0, 0, 5, 10, 1'b0);
		send_vertex(0, 0, -5, 10, 1'b1);
		// query far outside a square
		send_vertex(-32768, -32768, -100, -100, 1'b0);
		send_vertex(0, 0, 100, -100, 1'b0);
		send_vertex(0, 0, 100, 100, 1'b0);
		send_vertex(0, 0, -100, 100, 1'b1);
		// long polygon around the query
		send_vertex(100, -100, 150, -100, 1'b0);
		send_vertex(0, 0, 125, -60, 1'b0);
		send_vertex(0, 0, 75, -60, 1'b0);
		send_vertex(0, 0, 50, -100, 1'b0);
		send_vertex(0, 0, 75, -140, 1'b0);
		send_vertex(0, 0, 125, -140, 1'b1);
		wait_for_results();

		while (sb.requests < 360)
			send_random_polygon();
		wait_for_results();
		send_idle_pct  = 66;
		recv_stall_pct = 18;
		while (sb.requests < 700)
			send_random_polygon();
		wait_for_results();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (sb.requests < 1050)
			send_random_polygon();
		wait_for_results();
		repeat (8) @(posedge clk);

		$display("covered %0d vertex requests, %0d polygon results checked",
			sb.requests, sb.results);
		$display("%0d results inside, %0d short polygons", sb.inside_hits, sb.short_polys);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_front.sv
rtl/pip_queue.sv
rtl/pip_back.sv
rtl/point_in_polygon_test_unit.sv
bench/point_in_polygon_test_unit_tb.sv
